@@ design/jef_pkg.sv @@
// Shared types and constants for the JPEG extent finder.
package jef_pkg;

    typedef enum logic [2:0] {
        PH_SOI0,
        PH_SOI1,
        PH_MHI,
        PH_MLO,
        PH_LHI,
        PH_LLO,
        PH_SKIP,
        PH_SCAN
    } jef_phase_t;

    localparam logic [1:0] CAUSE_EOI     = 2'd0;
    localparam logic [1:0] CAUSE_UNKNOWN = 2'd1;
    localparam logic [1:0] CAUSE_LIMIT   = 2'd2;
    localparam logic [1:0] CAUSE_END     = 2'd3;

    localparam logic CFG_BASE_SIZE = 1'b0;
    localparam logic CFG_MAX_SCAN  = 1'b1;

    localparam logic [15:0] MAX_SCAN_RESET = 16'hffff;

    localparam logic [7:0] BYTE_FF  = 8'hff;
    localparam logic [7:0] CODE_EOI = 8'hd9;
    localparam logic [7:0] CODE_SOS = 8'hda;
    localparam logic [7:0] CODE_DQT = 8'hdb;
    localparam logic [7:0] CODE_SOF = 8'hc0;
    localparam logic [7:0] CODE_DHT = 8'hc4;
    localparam logic [7:0] CODE_DRI = 8'hdd;
    localparam logic [3:0] APP_HIGH = 4'he;

    typedef struct packed {
        logic        found;
        logic        complete;
        logic [1:0]  stop_cause;
        logic [31:0] image_size;
    } jef_result_t;

endpackage

@@ design/jpeg_extent_finder_top.sv @@
// Top level of the JPEG extent finder: input stage, parser, result register, config.
//
// Takes one buffer byte per cycle and reports the length of the JPEG image at
// the start of the buffer. A byte is held in the input register and is parsed
// on its way into the result register. Throughput is one byte per clock while
// the input does not stall; the input stalls only when a result is due and the
// result register is still held by the consumer.
// At most one result is produced per buffer: when the parse stops (end of
// image, unknown marker, scan limit) or at the byte flagged last_byte.
// Registers: index 0 base_size, index 1 max_scan_bytes; write them only
// while no request is in flight.
module jpeg_extent_finder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic        complete,
    output logic [1:0]  stop_cause,
    output logic [31:0] image_size,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_advance;
    logic [31:0] base_size_reg;
    logic [15:0] max_scan_reg;
    logic        out_valid_reg;
    jef_pkg::jef_result_t result_reg;
    jef_pkg::jef_result_t parse_result;
    logic        parse_emit;

    jef_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (s1_advance),
        .data_byte      (s1_byte_reg),
        .last_byte      (s1_last_reg),
        .base_size      (base_size_reg),
        .max_scan_bytes (max_scan_reg),
        .emit           (parse_emit),
        .result         (parse_result)
    );

    assign s1_advance = s1_valid_reg && (!parse_emit || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance && parse_emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && parse_emit)
            result_reg <= parse_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_size_reg <= 32'd0;
            max_scan_reg  <= jef_pkg::MAX_SCAN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                jef_pkg::CFG_BASE_SIZE: base_size_reg <= cfg_data;
                jef_pkg::CFG_MAX_SCAN:  max_scan_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = result_reg.found;
    assign complete   = result_reg.complete;
    assign stop_cause = result_reg.stop_cause;
    assign image_size = result_reg.image_size;

endmodule

@@ design/jef_parser.sv @@
// Marker and segment parse state, updated once per byte, with result forming.
module jef_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic [31:0]          base_size,
    input  logic [15:0]          max_scan_bytes,
    output logic                 emit,
    output jef_pkg::jef_result_t result
);

    jef_pkg::jef_phase_t phase_reg, phase_next;
    logic [7:0]  marker_high_reg, marker_high_next;
    logic [15:0] bytes_to_skip_reg, bytes_to_skip_next;
    logic [31:0] byte_count_reg, byte_count_next;
    logic [15:0] scan_count_reg, scan_count_next;
    logic        after_ff_reg, after_ff_next;
    logic        seen_segment_reg, seen_segment_next;
    logic        is_sos_reg, is_sos_next;
    logic        finished_reg, finished_next;

    logic        stop_now;
    logic [1:0]  cause_now;
    logic [31:0] count_inc;
    logic [32:0] size_sum;
    logic [15:0] seg_len;
    logic [15:0] seg_left;
    logic [15:0] skip_dec;
    logic        marker_ok;

    function automatic logic marker_accepted(input logic [7:0] hi, input logic [7:0] lo);
        logic ok;
        ok = 1'b0;
        if (hi == jef_pkg::BYTE_FF)
        begin
            ok = (lo[7:4] == jef_pkg::APP_HIGH) || (lo == jef_pkg::CODE_DQT)
                || (lo == jef_pkg::CODE_SOF) || (lo == jef_pkg::CODE_DHT)
                || (lo == jef_pkg::CODE_DRI) || (lo == jef_pkg::CODE_SOS)
                || (lo == jef_pkg::CODE_EOI);
        end
        return ok;
    endfunction

    assign count_inc = (byte_count_reg == 32'hffffffff) ? byte_count_reg
                                                        : byte_count_reg + 32'd1;
    // base + count + 1 in one add; a saturated count always overflows anyway
    assign size_sum  = {1'b0, base_size} + {1'b0, byte_count_reg} + 33'd1;
    assign seg_len   = {bytes_to_skip_reg[15:8], data_byte};
    assign seg_left  = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
    assign skip_dec  = bytes_to_skip_reg - 16'd1;
    assign marker_ok = marker_accepted(marker_high_reg, data_byte);

    // next state
    always_comb
    begin
        phase_next         = phase_reg;
        marker_high_next   = marker_high_reg;
        bytes_to_skip_next = bytes_to_skip_reg;
        byte_count_next    = byte_count_reg;
        scan_count_next    = scan_count_reg;
        after_ff_next      = after_ff_reg;
        seen_segment_next  = seen_segment_reg;
        is_sos_next        = is_sos_reg;
        finished_next      = finished_reg;
        stop_now           = 1'b0;
        cause_now          = jef_pkg::CAUSE_END;

        if (!finished_reg)
        begin
            byte_count_next = count_inc;
            unique case (phase_reg)
                jef_pkg::PH_SOI0: phase_next = jef_pkg::PH_SOI1;
                jef_pkg::PH_SOI1: phase_next = jef_pkg::PH_MHI;
                jef_pkg::PH_MHI:
                begin
                    marker_high_next = data_byte;
                    phase_next       = jef_pkg::PH_MLO;
                end
                jef_pkg::PH_MLO:
                begin
                    if (!marker_ok)
                    begin
                        stop_now  = 1'b1;
                        cause_now = jef_pkg::CAUSE_UNKNOWN;
                    end
                    else
                    begin
                        seen_segment_next = 1'b1;
                        if (data_byte == jef_pkg::CODE_EOI)
                        begin
                            stop_now  = 1'b1;
                            cause_now = jef_pkg::CAUSE_EOI;
                        end
                        else
                        begin
                            is_sos_next = (data_byte == jef_pkg::CODE_SOS);
                            phase_next  = jef_pkg::PH_LHI;
                        end
                    end
                end
                jef_pkg::PH_LHI:
                begin
                    bytes_to_skip_next = {data_byte, 8'h00};
                    phase_next         = jef_pkg::PH_LLO;
                end
                jef_pkg::PH_LLO:
                begin
                    bytes_to_skip_next = seg_left;
                    if (seg_left != 16'd0)
                        phase_next = jef_pkg::PH_SKIP;
                    else if (is_sos_reg)
                    begin
                        phase_next      = jef_pkg::PH_SCAN;
                        scan_count_next = 16'd0;
                        after_ff_next   = 1'b0;
                    end
                    else
                        phase_next = jef_pkg::PH_MHI;
                end
                jef_pkg::PH_SKIP:
                begin
                    bytes_to_skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        if (is_sos_reg)
                        begin
                            phase_next      = jef_pkg::PH_SCAN;
                            scan_count_next = 16'd0;
                            after_ff_next   = 1'b0;
                        end
                        else
                            phase_next = jef_pkg::PH_MHI;
                    end
                end
                jef_pkg::PH_SCAN:
                begin
                    if (after_ff_reg && data_byte == jef_pkg::CODE_EOI)
                    begin
                        stop_now  = 1'b1;
                        cause_now = jef_pkg::CAUSE_EOI;
                    end
                    else if (after_ff_reg && data_byte == jef_pkg::CODE_SOS)
                    begin
                        seen_segment_next = 1'b1;
                        is_sos_next       = 1'b1;
                        after_ff_next     = 1'b0;
                        phase_next        = jef_pkg::PH_LHI;
                    end
                    else if (scan_count_reg >= max_scan_bytes)
                    begin
                        stop_now  = 1'b1;
                        cause_now = jef_pkg::CAUSE_LIMIT;
                    end
                    else
                    begin
                        scan_count_next = scan_count_reg + 16'd1;
                        after_ff_next   = (data_byte == jef_pkg::BYTE_FF);
                    end
                end
                default: phase_next = jef_pkg::PH_SOI0;
            endcase
            if (stop_now || last_byte)
                finished_next = 1'b1;
        end

        if (last_byte)
        begin
            phase_next         = jef_pkg::PH_SOI0;
            marker_high_next   = 8'h00;
            bytes_to_skip_next = 16'd0;
            byte_count_next    = 32'd0;
            scan_count_next    = 16'd0;
            after_ff_next      = 1'b0;
            seen_segment_next  = 1'b0;
            is_sos_next        = 1'b0;
            finished_next      = 1'b0;
        end
    end

    // outputs
    always_comb
    begin
        emit              = !finished_reg && (stop_now || last_byte);
        result.found      = seen_segment_next || (seen_segment_reg && last_byte);
        result.complete   = stop_now && (cause_now == jef_pkg::CAUSE_EOI);
        result.stop_cause = stop_now ? cause_now : jef_pkg::CAUSE_END;
        result.image_size = size_sum[32] ? 32'hffffffff : size_sum[31:0];
        if (!last_byte)
            result.found = seen_segment_next;
        else
        begin
            // found reflects this byte's update even though state is cleared
            result.found = seen_segment_reg
                || (phase_reg == jef_pkg::PH_MLO && marker_ok)
                || (phase_reg == jef_pkg::PH_SCAN && after_ff_reg
                    && data_byte == jef_pkg::CODE_SOS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= jef_pkg::PH_SOI0;
            marker_high_reg   <= 8'h00;
            bytes_to_skip_reg <= 16'd0;
            byte_count_reg    <= 32'd0;
            scan_count_reg    <= 16'd0;
            after_ff_reg      <= 1'b0;
            seen_segment_reg  <= 1'b0;
            is_sos_reg        <= 1'b0;
            finished_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            marker_high_reg   <= marker_high_next;
            bytes_to_skip_reg <= bytes_to_skip_next;
            byte_count_reg    <= byte_count_next;
            scan_count_reg    <= scan_count_next;
            after_ff_reg      <= after_ff_next;
            seen_segment_reg  <= seen_segment_next;
            is_sos_reg        <= is_sos_next;
            finished_reg      <= finished_next;
        end
    end

endmodule

@@ design/jef_checker.sv @@
// Port-level checks for the JPEG extent finder, bound to the top level.
module jef_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        found,
    input logic        complete,
    input logic [1:0]  stop_cause,
    input logic [31:0] image_size
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(complete)
            && $stable(stop_cause) && $stable(image_size) && $stable(found))
        else $error("result changed while stalled");

    a_complete_eoi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && complete |-> stop_cause == jef_pkg::CAUSE_EOI && found)
        else $error("complete without end-of-image cause");

    a_eoi_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stop_cause == jef_pkg::CAUSE_EOI |-> complete)
        else $error("end-of-image cause without complete");

    a_limit_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stop_cause == jef_pkg::CAUSE_LIMIT |-> found && !complete)
        else $error("scan limit without a scan header");

endmodule

bind jpeg_extent_finder_top jef_checker u_jef_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .complete   (complete),
    .stop_cause (stop_cause),
    .image_size (image_size)
);

@@ tb/sv/jpeg_extent_finder_top_tb.sv @@
// Self-checking testbench for the JPEG extent finder: byte stream in, image extent out.
module jpeg_extent_finder_top_tb;

    localparam int          ITEM_TARGET    = 1250;
    localparam int          PHASE_BYTES    = 160;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          HOLD_OFF_LEN   = 300;
    localparam int          SETTLE_CYCLES  = 8;
    localparam logic [31:0] SIZE_SAT       = 32'hffff_ffff;
    localparam logic [7:0]  CODE_SOI       = 8'hd8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } buf_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        found;
    logic        complete;
    logic [1:0]  stop_cause;
    logic [31:0] image_size;
    logic        cfg_we = 1'b0;
    logic        cfg_index = jef_pkg::CFG_BASE_SIZE;
    logic [31:0] cfg_data = 32'h0;

    // predictor state
    logic [31:0]         base_total = 32'h0;
    logic [15:0]         scan_limit = jef_pkg::MAX_SCAN_RESET;
    jef_pkg::jef_phase_t cur_phase;
    logic [7:0]          mark_hi;
    logic [15:0]         skip_left;
    logic [31:0]         consumed;
    logic [15:0]         scan_run;
    bit                  prev_ff;
    bit                  any_segment;
    bit                  in_sos;
    bit                  stopped;
    bit                  eoi_hit;
    logic [1:0]          stop_code;

    jef_pkg::jef_result_t expected_extents[$];
    buf_byte_t            pending_bytes[$];
    logic [7:0]           frame_bytes[$];

    int                   queued_count = 0;
    int                   accepted_count = 0;
    int                   reports_seen = 0;
    int                   error_count = 0;
    int                   idle_cycles = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   hold_off_tickets = 0;
    int                   hold_off_served = 0;
    int                   hold_off_left = 0;
    bit                   in_taken = 1'b0;
    buf_byte_t            next_req;
    jef_pkg::jef_result_t want;

    jpeg_extent_finder_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .complete   (complete),
        .stop_cause (stop_cause),
        .image_size (image_size),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_parse();
        cur_phase   = jef_pkg::PH_SOI0;
        mark_hi     = 8'h00;
        skip_left   = 16'h0;
        consumed    = 32'h0;
        scan_run    = 16'h0;
        prev_ff     = 1'b0;
        any_segment = 1'b0;
        in_sos      = 1'b0;
        stopped     = 1'b0;
        eoi_hit     = 1'b0;
        stop_code   = jef_pkg::CAUSE_END;
    endfunction

    function automatic bit known_marker(input logic [15:0] m);
        if (m[15:8] != jef_pkg::BYTE_FF)
            return 1'b0;
        return (m[7:4] == jef_pkg::APP_HIGH) ||
               (m[7:0] inside {jef_pkg::CODE_DQT, jef_pkg::CODE_SOF, jef_pkg::CODE_DHT,
                               jef_pkg::CODE_DRI, jef_pkg::CODE_SOS, jef_pkg::CODE_EOI});
    endfunction

    function automatic void halt(input logic [1:0] code);
        stopped   = 1'b1;
        stop_code = code;
        if (code == jef_pkg::CAUSE_EOI)
            eoi_hit = 1'b1;
    endfunction

    function automatic void end_segment();
        if (in_sos)
        begin
            cur_phase = jef_pkg::PH_SCAN;
            scan_run  = 16'h0;
            prev_ff   = 1'b0;
        end
        else
            cur_phase = jef_pkg::PH_MHI;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        logic [15:0] mark;
        logic [15:0] seg_len;
        if (consumed != SIZE_SAT)
            consumed++;
        case (cur_phase)
            jef_pkg::PH_SOI0: cur_phase = jef_pkg::PH_SOI1;
            jef_pkg::PH_SOI1: cur_phase = jef_pkg::PH_MHI;
            jef_pkg::PH_MHI:
            begin
                mark_hi   = b;
                cur_phase = jef_pkg::PH_MLO;
            end
            jef_pkg::PH_MLO:
            begin
                mark = {mark_hi, b};
                if (!known_marker(mark))
                    halt(jef_pkg::CAUSE_UNKNOWN);
                else
                begin
                    any_segment = 1'b1;
                    if (mark == {jef_pkg::BYTE_FF, jef_pkg::CODE_EOI})
                        halt(jef_pkg::CAUSE_EOI);
                    else
                    begin
                        in_sos    = (mark == {jef_pkg::BYTE_FF, jef_pkg::CODE_SOS});
                        cur_phase = jef_pkg::PH_LHI;
                    end
                end
            end
            jef_pkg::PH_LHI:
            begin
                skip_left = {b, 8'h00};
                cur_phase = jef_pkg::PH_LLO;
            end
            jef_pkg::PH_LLO:
            begin
                seg_len   = {skip_left[15:8], b};
                skip_left = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
                if (skip_left == 16'd0)
                    end_segment();
                else
                    cur_phase = jef_pkg::PH_SKIP;
            end
            jef_pkg::PH_SKIP:
            begin
                skip_left--;
                if (skip_left == 16'd0)
                    end_segment();
            end
            default:
            begin
                if (prev_ff && b == jef_pkg::CODE_EOI)
                    halt(jef_pkg::CAUSE_EOI);
                else if (prev_ff && b == jef_pkg::CODE_SOS)
                begin
                    any_segment = 1'b1;
                    in_sos      = 1'b1;
                    prev_ff     = 1'b0;
                    cur_phase   = jef_pkg::PH_LHI;
                end
                else if (scan_run >= scan_limit)
                    halt(jef_pkg::CAUSE_LIMIT);
                else
                begin
                    scan_run++;
                    prev_ff = (b == jef_pkg::BYTE_FF);
                end
            end
        endcase
    endfunction

    function automatic void predict_extent(input logic [7:0] b, input logic last);
        logic [32:0]          sum;
        jef_pkg::jef_result_t r;
        if (!stopped)
        begin
            parse_byte(b);
            if (stopped || last)
            begin
                sum          = {1'b0, base_total} + {1'b0, consumed};
                r.found      = any_segment;
                r.complete   = eoi_hit;
                r.stop_cause = stopped ? stop_code : jef_pkg::CAUSE_END;
                r.image_size = sum[32] ? SIZE_SAT : sum[31:0];
                expected_extents.push_back(r);
                stopped = 1'b1;
            end
        end
        if (last)
            clear_parse();
    endfunction

    // request side: valid holds with its payload until taken
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = pending_bytes.pop_front();
                in_valid  <= 1'b1;
                data_byte <= next_req.data;
                last_byte <= next_req.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_off_tickets != hold_off_served)
        begin
            hold_off_served = hold_off_served + 1;
            hold_off_left   = HOLD_OFF_LEN;
        end
        if (hold_off_left != 0)
        begin
            hold_off_left = hold_off_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        in_taken = in_valid && in_ready;
        if (in_taken)
        begin
            predict_extent(data_byte, last_byte);
            accepted_count++;
        end
        if (out_valid && out_ready)
        begin
            reports_seen++;
            if (expected_extents.size() == 0)
            begin
                $error("unexpected result: found %0d complete %0d cause %0d size %h",
                       found, complete, stop_cause, image_size);
                error_count++;
            end
            else
            begin
                want = expected_extents.pop_front();
                if (found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, found);
                    error_count++;
                end
                if (complete !== want.complete)
                begin
                    $error("complete: expected %0d, actual %0d", want.complete, complete);
                    error_count++;
                end
                if (stop_cause !== want.stop_cause)
                begin
                    $error("stop_cause: expected %0d, actual %0d", want.stop_cause, stop_cause);
                    error_count++;
                end
                if (image_size !== want.image_size)
                begin
                    $error("image_size: expected %h, actual %h", want.image_size, image_size);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == jef_pkg::CFG_BASE_SIZE)
            base_total = val;
        else
            scan_limit = val[15:0];
    endtask

    task automatic settle();
        while (accepted_count != queued_count || expected_extents.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void queue_frame(input int n);
        buf_byte_t item;
        for (int i = 0; i < n; i++)
        begin
            item.data = frame_bytes[i];
            item.last = (i == n - 1);
            pending_bytes.push_back(item);
            queued_count++;
        end
    endfunction

    function automatic void add_segment(input logic [7:0] code, input int seg_len);
        frame_bytes.push_back(jef_pkg::BYTE_FF);
        frame_bytes.push_back(code);
        frame_bytes.push_back(8'(seg_len >> 8));
        frame_bytes.push_back(8'(seg_len));
        for (int i = 2; i < seg_len; i++)
            frame_bytes.push_back(8'($urandom));
    endfunction

    // entropy data with stuffing, restarts and fill bytes mixed in
    function automatic void add_scan(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 10)
            begin
                frame_bytes.push_back(jef_pkg::BYTE_FF);
                case ($urandom_range(3))
                    0: frame_bytes.push_back(8'h00);
                    1: frame_bytes.push_back(8'hd0 | 8'($urandom_range(7)));
                    2: frame_bytes.push_back(jef_pkg::BYTE_FF);
                    default: frame_bytes.push_back(8'($urandom));
                endcase
            end
            else
                frame_bytes.push_back(8'($urandom));
        end
    endfunction

    function automatic int pick_len();
        case ($urandom_range(19))
            0: return $urandom_range(1);
            1: return $urandom_range(300, 13);
            default: return $urandom_range(8, 2);
        endcase
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(4))
            0: return {jef_pkg::APP_HIGH, 4'($urandom)};
            1: return jef_pkg::CODE_DQT;
            2: return jef_pkg::CODE_SOF;
            3: return jef_pkg::CODE_DHT;
            default: return jef_pkg::CODE_DRI;
        endcase
    endfunction

    function automatic void build_image();
        int cut;
        frame_bytes.delete();
        if ($urandom_range(9) == 0)
        begin
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back(8'($urandom));
        end
        else
        begin
            frame_bytes.push_back(jef_pkg::BYTE_FF);
            frame_bytes.push_back(CODE_SOI);
        end
        repeat ($urandom_range(3))
        begin
            if ($urandom_range(19) == 0)
            begin
                frame_bytes.push_back(jef_pkg::BYTE_FF);
                frame_bytes.push_back(8'($urandom));
            end
            else
                add_segment(pick_code(), pick_len());
        end
        if ($urandom_range(9) != 0)
        begin
            add_segment(jef_pkg::CODE_SOS, pick_len());
            add_scan($urandom_range(24));
            if ($urandom_range(4) == 0)
            begin
                add_segment(jef_pkg::CODE_SOS, pick_len());
                add_scan($urandom_range(24));
            end
        end
        if ($urandom_range(9) != 0)
        begin
            frame_bytes.push_back(jef_pkg::BYTE_FF);
            frame_bytes.push_back(jef_pkg::CODE_EOI);
        end
        repeat ($urandom_range(3))
            frame_bytes.push_back(8'($urandom));
        cut = ($urandom_range(7) == 0) ? $urandom_range(frame_bytes.size(), 1)
                                        : frame_bytes.size();
        queue_frame(cut);
    endfunction

    function automatic void build_noise();
        frame_bytes.delete();
        repeat ($urandom_range(20, 1))
            frame_bytes.push_back(8'($urandom));
        queue_frame(frame_bytes.size());
    endfunction

    initial
    begin
        int          phase_idx;
        int          phase_start;
        logic [31:0] base_pick;
        logic [31:0] limit_pick;
        clear_parse();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // end of image outside a scan
        frame_bytes = {jef_pkg::BYTE_FF, CODE_SOI, jef_pkg::BYTE_FF, jef_pkg::CODE_EOI};
        queue_frame(frame_bytes.size());
        // short length, stuffing, fill byte before end, then ignored tail
        frame_bytes = {jef_pkg::BYTE_FF, CODE_SOI, jef_pkg::BYTE_FF,
                       {jef_pkg::APP_HIGH, 4'h0}, 8'h00, 8'h00,
                       jef_pkg::BYTE_FF, jef_pkg::CODE_SOS, 8'h00, 8'h03, 8'hab,
                       jef_pkg::BYTE_FF, 8'h00, jef_pkg::BYTE_FF, jef_pkg::BYTE_FF,
                       jef_pkg::CODE_EOI, 8'h5a};
        queue_frame(frame_bytes.size());
        // unknown marker right after SOI
        frame_bytes = {jef_pkg::BYTE_FF, CODE_SOI, jef_pkg::BYTE_FF, 8'h01};
        queue_frame(frame_bytes.size());
        settle();

        // long consumer hold-off while requests keep coming
        hold_off_tickets = hold_off_tickets + 1;
        repeat (6) build_image();
        settle();

        phase_idx = 0;
        while (queued_count < ITEM_TARGET)
        begin
            case (phase_idx % 4)
                0: base_pick = 32'h0;
                1: base_pick = SIZE_SAT;
                2: base_pick = SIZE_SAT - $urandom_range(100);
                default: base_pick = $urandom;
            endcase
            case (phase_idx % 3)
                0: limit_pick = {16'h0, jef_pkg::MAX_SCAN_RESET};
                1: limit_pick = 32'd1;
                default: limit_pick = $urandom_range(24, 2);
            endcase
            write_reg(jef_pkg::CFG_BASE_SIZE, base_pick);
            write_reg(jef_pkg::CFG_MAX_SCAN, limit_pick);
            case (phase_idx % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 58;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 58;
                end
                default:
                begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            phase_start = queued_count;
            while (queued_count - phase_start < PHASE_BYTES)
            begin
                if ($urandom_range(99) < 15)
                    build_noise();
                else
                    build_image();
            end
            settle();
            phase_idx++;
        end

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
design/jef_pkg.sv
design/jef_parser.sv
design/jpeg_extent_finder_top.sv
design/jef_checker.sv
tb/sv/jpeg_extent_finder_top_tb.sv
